// ===== hdl/siah_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package siah_pkg;
  localparam logic [2:0] OP_RESTART = 3'd0;
  localparam logic [2:0] OP_STEP    = 3'd1;
  localparam logic [2:0] OP_PLOT    = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_RDCLR   = 3'd4;

  localparam logic [2:0] CFG_LAMBDA = 3'd0;
  localparam logic [2:0] CFG_ALPHA  = 3'd1;
  localparam logic [2:0] CFG_BETA   = 3'd2;
  localparam logic [2:0] CFG_GAMMA  = 3'd3;
  localparam logic [2:0] CFG_DELTA  = 3'd4;
  localparam logic [2:0] CFG_OMEGA  = 3'd5;
  localparam logic [2:0] CFG_DEGREE = 3'd6;
  localparam logic [2:0] CFG_INVEXT = 3'd7;

  localparam logic signed [31:0] RESET_RE = 32'sd268435;
  localparam logic signed [31:0] RESET_IM = 32'sd536871;
  localparam logic signed [31:0] FX_ONE   = 32'sh1000_0000;

  // shared unit operations
  localparam logic [1:0] ALU_MUL = 2'd0;
  localparam logic [1:0] ALU_ADD = 2'd1;
  localparam logic [1:0] ALU_SUB = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fff_ffff;
    else if (v < -66'sd2147483648) return 32'sh8000_0000;
    else return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== hdl/siah_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
module siah_alu (
  input  wire                    clk,
  input  siah_pkg::alu_req_t     req,
  output logic signed [31:0]     res
);
  import siah_pkg::*;
  logic signed [63:0] prod;
  logic signed [65:0] wide;
  logic signed [31:0] res_nxt;

  // rounded fixed-point product or saturating add/sub
  always_comb begin
    prod = 64'(req.a) * 64'(req.b);
    unique case (req.op)
      ALU_MUL: wide = 66'((prod + 64'sd134217728) >>> 28);
      ALU_ADD: wide = 66'(req.a) + 66'(req.b);
      ALU_SUB: wide = 66'(req.a) - 66'(req.b);
      default: wide = 66'(req.a);
    endcase
    res_nxt = sat32(wide);
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/siah_sqdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none
// iterative integer square root and signed division
module siah_sqdiv (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                sq_go,
  input  wire [59:0]         sq_val,
  input  wire                dv_go,
  input  wire signed [31:0]  dv_num,
  input  wire [31:0]         dv_den,
  output logic               done,
  output logic [31:0]        sq_res,
  output logic signed [31:0] dv_res
);
  import siah_pkg::*;
  logic        busy_r, busy_nxt, mode_r, mode_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic [63:0] trial;
  logic [63:0] q_mag;

  always_comb begin
    busy_nxt = busy_r; mode_nxt = mode_r; cnt_nxt = cnt_r;
    rem_nxt = rem_r; acc_nxt = acc_r; den_nxt = den_r; neg_nxt = neg_r;
    trial = '0;
    done_nxt = 1'b0;
    if (sq_go) begin
      busy_nxt = 1'b1; mode_nxt = 1'b0; cnt_nxt = 6'd30;
      rem_nxt = {4'd0, sq_val}; acc_nxt = '0;
    end else if (dv_go) begin
      busy_nxt = 1'b1; mode_nxt = 1'b1; cnt_nxt = 6'd60;
      neg_nxt = dv_num[31];
      rem_nxt = 64'(dv_num[31] ? -33'(dv_num) : 33'(dv_num)) << 28;
      acc_nxt = '0; den_nxt = 64'(dv_den);
    end else if (busy_r) begin
      if (!mode_r) begin
        // one result bit per cycle, two radicand bits
        trial = acc_r + (64'd1 << (2 * (cnt_r - 6'd1)));
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          acc_nxt = (acc_r >> 1) + (64'd1 << (2 * (cnt_r - 6'd1)));
        end else begin
          acc_nxt = acc_r >> 1;
        end
      end else begin
        // restoring division, one quotient bit per cycle
        trial = den_r << (cnt_r - 6'd1);
        if ((rem_r >> (cnt_r - 6'd1)) >= den_r) begin
          rem_nxt = rem_r - trial;
          acc_nxt = acc_r | (64'd1 << (cnt_r - 6'd1));
        end
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mode_r <= mode_nxt; cnt_r <= cnt_nxt; rem_r <= rem_nxt;
    acc_r <= acc_nxt; den_r <= den_nxt; neg_r <= neg_nxt;
  end

  // done is raised once the last bit sits in the accumulator
  assign done = done_r;

  always_comb begin
    sq_res = acc_r[31:0];
    q_mag = acc_r;
    if (q_mag > 64'd2147483648) dv_res = neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else if (q_mag == 64'd2147483648) dv_res = neg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    else dv_res = neg_r ? -q_mag[31:0] : q_mag[31:0];
  end
endmodule
`default_nettype wire

// ===== hdl/siah_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module siah_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hdl/symmetric_icon_attractor_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Symmetric icon attractor with a density histogram.
// Input channel: in_opcode, in_bin_col, in_bin_row taken when start is high
// and busy is low. Opcodes: restart, step, step-and-plot, read bin, read and
// clear bin. Result: out_* ports valid for one cycle with done high; the
// receiver cannot stall, so nothing is held back.
// Configuration: cfg_we, cfg_index, cfg_data write a register at once.
// Busy is already low in the done cycle, so the next item can be taken in
// that cycle. Restart and unused opcodes go straight to done; a read goes
// through the bin memory, or straight to done when off the canvas.
// A step runs every multiply and add through one shared saturating unit,
// each op issued in one phase and written back in the next. With delta
// nonzero a square root is added, and unless the magnitude is zero also two
// divides, the power loop and the delta product.
// Plot adds the pixel map, and a bin update when the point lands on the canvas.
// Reset: coefficients return to defaults, the point to (0.001, 0.002), and a
// clearing pass writes every bin to zero, one per cycle, while busy stays
// high; config writes are still taken.
module symmetric_icon_attractor_histogram #(
  parameter int CANVAS_WIDTH  = 1024,
  parameter int CANVAS_HEIGHT = 1024,
  parameter int POWER_MULT    = 1
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire [2:0]          in_opcode,
  input  wire [9:0]          in_bin_col,
  input  wire [9:0]          in_bin_row,
  output logic               done,
  output logic signed [31:0] out_point_real,
  output logic signed [31:0] out_point_imag,
  output logic               out_in_view,
  output logic [9:0]         out_hit_col,
  output logic [9:0]         out_hit_row,
  output logic [15:0]        out_bin_count,
  input  wire                cfg_we,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data
);
  import siah_pkg::*;
  localparam int DEPTH = CANVAS_WIDTH * CANVAS_HEIGHT;
  localparam int AW = $clog2(DEPTH);

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_RUN = 5'd2,
                         S_WAIT = 5'd3,   S_SQ = 5'd4,    S_DVR = 5'd5,
                         S_DVI = 5'd6,    S_PIXA = 5'd7,  S_PIXB = 5'd8,
                         S_PIXC = 5'd9,   S_RDA = 5'd10,  S_RDB = 5'd11,
                         S_DONE = 5'd12;

  // configuration registers
  logic signed [31:0] lam_r, alp_r, bet_r, gam_r, del_r, omg_r;
  logic [4:0]  deg_r;
  logic [30:0] inv_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lam_r <= '0; alp_r <= '0; bet_r <= '0; gam_r <= '0; del_r <= '0; omg_r <= '0;
      deg_r <= 5'd3; inv_r <= 31'h1000_0000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAMBDA: lam_r <= cfg_data;
        CFG_ALPHA:  alp_r <= cfg_data;
        CFG_BETA:   bet_r <= cfg_data;
        CFG_GAMMA:  gam_r <= cfg_data;
        CFG_DELTA:  del_r <= cfg_data;
        CFG_OMEGA:  omg_r <= cfg_data;
        CFG_DEGREE: deg_r <= cfg_data[4:0];
        CFG_INVEXT: inv_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [4:0] st_r, st_nxt;
  logic [5:0] pc_r, pc_nxt;       // microprogram step
  logic [7:0] k_r, k_nxt;         // loop counter
  logic       ph_r, ph_nxt;       // issue / writeback phase
  logic [2:0] op_r, op_nxt;
  logic [9:0] col_r, col_nxt, row_r, row_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic signed [31:0] re_r, re_nxt, im_r, im_nxt;
  // scratch registers of the step program
  logic signed [31:0] nrm_r, nrm_nxt, pr_r, pr_nxt, pi_r, pi_nxt;
  logic signed [31:0] ur_r, ur_nxt, ui_r, ui_nxt, cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [31:0] t0_r, t0_nxt, t1_r, t1_nxt, ext_r, ext_nxt, g_r, g_nxt;
  logic signed [31:0] mag_r, mag_nxt, nre_r, nre_nxt;
  logic signed [63:0] px_r, px_nxt, py_r, py_nxt;
  logic               view_r, view_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic signed [31:0] o_re_r, o_im_r;
  logic               o_v_r;
  logic [9:0]         o_c_r, o_rw_r;
  logic [15:0]        o_n_r;
  logic               done_r, done_nxt;

  alu_req_t req;
  logic signed [31:0] alu_res;
  siah_alu u_alu (.clk(clk), .req(req), .res(alu_res));

  logic sq_go, dv_go, sd_done;
  logic [59:0] sq_val;
  logic signed [31:0] dv_num;
  logic [31:0] sq_res;
  logic signed [31:0] dv_res;
  siah_sqdiv u_sd (.clk(clk), .rst_n(rst_n), .sq_go(sq_go), .sq_val(sq_val),
    .dv_go(dv_go), .dv_num(dv_num), .dv_den(mag_nxt), .done(sd_done),
    .sq_res(sq_res), .dv_res(dv_res));

  logic we;
  logic [AW-1:0] waddr, raddr, ridx_r, ridx_nxt;
  logic [15:0] wdata, rdata;
  siah_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (.clk(clk), .we(we), .waddr(waddr),
    .wdata(wdata), .raddr(raddr), .rdata(rdata));

  logic [7:0] n_eff;
  logic [7:0] np;
  assign n_eff = (deg_r < 5'd2) ? 8'd2 : {3'd0, deg_r};
  assign np = 8'(n_eff * POWER_MULT);

  logic signed [63:0] sx, sy, cx, cy;

  // program: each pc issues one ALU op (ph 0) and writes back (ph 1)
  always_comb begin
    st_nxt = st_r; pc_nxt = pc_r; k_nxt = k_r; ph_nxt = ph_r;
    op_nxt = op_r; col_nxt = col_r; row_nxt = row_r; clr_nxt = clr_r;
    re_nxt = re_r; im_nxt = im_r; nrm_nxt = nrm_r; pr_nxt = pr_r; pi_nxt = pi_r;
    ur_nxt = ur_r; ui_nxt = ui_r; cr_nxt = cr_r; ci_nxt = ci_r;
    t0_nxt = t0_r; t1_nxt = t1_r; ext_nxt = ext_r; g_nxt = g_r;
    mag_nxt = mag_r; nre_nxt = nre_r; px_nxt = px_r; py_nxt = py_r;
    view_nxt = view_r; cnt_nxt = cnt_r; ridx_nxt = ridx_r; done_nxt = 1'b0;
    req = '{op: ALU_ADD, a: '0, b: '0};
    sq_go = 1'b0; dv_go = 1'b0; sq_val = '0; dv_num = '0;
    we = 1'b0; waddr = ridx_r; wdata = '0; raddr = ridx_r;
    sx = '0; sy = '0; cx = '0; cy = '0;
    unique case (st_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r; wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = in_opcode; col_nxt = in_bin_col; row_nxt = in_bin_row;
          view_nxt = 1'b0; cnt_nxt = '0; pc_nxt = '0; ph_nxt = 1'b0;
          pr_nxt = re_r; pi_nxt = im_r; ext_nxt = '0;
          unique case (in_opcode)
            OP_RESTART: begin
              re_nxt = RESET_RE; im_nxt = RESET_IM; st_nxt = S_DONE;
            end
            OP_STEP, OP_PLOT: st_nxt = S_RUN;
            OP_READ, OP_RDCLR: st_nxt = S_RDA;
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_RUN: begin
        // pc meaning: 0 re*re,1 im*im,2 norm add, then delta, power loop, tail
        unique case (pc_r)
          6'd0: req = '{op: ALU_MUL, a: re_r, b: re_r};
          6'd1: req = '{op: ALU_MUL, a: im_r, b: im_r};
          6'd2: req = '{op: ALU_ADD, a: t0_r, b: t1_r};
          6'd3: req = '{op: ALU_MUL, a: ur_r, b: cr_r};
          6'd4: req = '{op: ALU_MUL, a: ui_r, b: ci_r};
          6'd5: req = '{op: ALU_SUB, a: t0_r, b: t1_r};
          6'd6: req = '{op: ALU_MUL, a: ur_r, b: ci_r};
          6'd7: req = '{op: ALU_MUL, a: ui_r, b: cr_r};
          6'd8: req = '{op: ALU_ADD, a: t0_r, b: t1_r};
          6'd9: req = '{op: ALU_MUL, a: g_r, b: mag_r};
          6'd10: req = '{op: ALU_MUL, a: pr_r, b: re_r};
          6'd11: req = '{op: ALU_MUL, a: pi_r, b: im_r};
          6'd12: req = '{op: ALU_SUB, a: t0_r, b: t1_r};
          6'd13: req = '{op: ALU_MUL, a: pi_r, b: re_r};
          6'd14: req = '{op: ALU_MUL, a: pr_r, b: im_r};
          6'd15: req = '{op: ALU_ADD, a: t0_r, b: t1_r};
          6'd16: req = '{op: ALU_MUL, a: re_r, b: pr_r};
          6'd17: req = '{op: ALU_MUL, a: im_r, b: pi_r};
          6'd18: req = '{op: ALU_SUB, a: t0_r, b: t1_r};
          6'd19: req = '{op: ALU_MUL, a: alp_r, b: nrm_r};
          6'd20: req = '{op: ALU_ADD, a: lam_r, b: t0_r};
          6'd21: req = '{op: ALU_MUL, a: bet_r, b: nre_r};
          6'd22: req = '{op: ALU_ADD, a: g_r, b: t0_r};
          6'd23: req = '{op: ALU_MUL, a: del_r, b: ext_r};
          6'd24: req = '{op: ALU_ADD, a: g_r, b: t0_r};
          6'd25: req = '{op: ALU_MUL, a: g_r, b: re_r};
          6'd26: req = '{op: ALU_MUL, a: gam_r, b: pr_r};
          6'd27: req = '{op: ALU_ADD, a: t0_r, b: t1_r};
          6'd28: req = '{op: ALU_MUL, a: omg_r, b: im_r};
          6'd29: req = '{op: ALU_SUB, a: t0_r, b: t1_r};
          6'd30: req = '{op: ALU_MUL, a: g_r, b: im_r};
          6'd31: req = '{op: ALU_MUL, a: gam_r, b: pi_r};
          6'd32: req = '{op: ALU_SUB, a: t0_r, b: t1_r};
          6'd33: req = '{op: ALU_MUL, a: omg_r, b: re_r};
          6'd34: req = '{op: ALU_ADD, a: t0_r, b: t1_r};
          default: req = '{op: ALU_ADD, a: '0, b: '0};
        endcase
        ph_nxt = ~ph_r;
        if (ph_r) begin
          pc_nxt = pc_r + 6'd1;
          unique case (pc_r)
            6'd0, 6'd3, 6'd6, 6'd10, 6'd13, 6'd16, 6'd19, 6'd21, 6'd23, 6'd25,
            6'd30: t0_nxt = alu_res;
            6'd1, 6'd4, 6'd7, 6'd11, 6'd14, 6'd17, 6'd26, 6'd28, 6'd31,
            6'd33: t1_nxt = alu_res;
            6'd2: begin
              nrm_nxt = alu_res;
              if (del_r != 0) begin
                st_nxt = S_SQ; sq_go = 1'b1;
                sq_val = alu_res[31] ? '0 : 60'(alu_res) << 28;
              end else pc_nxt = 6'd10;
              k_nxt = '0;
            end
            // real part of the unit power parks in g until the imaginary part is done
            6'd5: g_nxt = alu_res;
            6'd8: begin
              cr_nxt = g_r; ci_nxt = alu_res;
              k_nxt = k_r + 8'd1;
              pc_nxt = (k_r + 8'd1 < np) ? 6'd3 : 6'd9;
            end
            6'd9: begin
              ext_nxt = alu_res; k_nxt = '0;
            end
            // real part of the next power parks in nre until pr is replaced
            6'd12: nre_nxt = alu_res;
            6'd15: begin
              pr_nxt = nre_r; pi_nxt = alu_res;
              k_nxt = k_r + 8'd1;
              pc_nxt = (k_r + 8'd3 < n_eff) ? 6'd10 : 6'd16;
            end
            6'd18: nre_nxt = alu_res;
            6'd20, 6'd22, 6'd24: g_nxt = alu_res;
            6'd27: t0_nxt = alu_res;
            6'd29: nre_nxt = alu_res;
            6'd32: t0_nxt = alu_res;
            6'd34: begin
              re_nxt = nre_r; im_nxt = alu_res;
              st_nxt = (op_r == OP_PLOT) ? S_PIXA : S_DONE;
            end
            default: ;
          endcase
          // skip the power loop entirely for degree two
          if (pc_r == 6'd9 || (pc_r == 6'd2 && del_r == 0)) begin
            if (n_eff < 8'd3) pc_nxt = 6'd16;
          end
        end
      end
      S_SQ: begin
        if (sd_done) begin
          mag_nxt = sq_res;
          if (sq_res == 0) begin
            st_nxt = S_RUN; pc_nxt = (n_eff < 8'd3) ? 6'd16 : 6'd10;
          end else begin
            st_nxt = S_DVR; dv_go = 1'b1; dv_num = re_r;
          end
        end
      end
      S_DVR: begin
        if (sd_done) begin
          ur_nxt = dv_res; st_nxt = S_DVI; dv_go = 1'b1; dv_num = im_r;
        end
      end
      S_DVI: begin
        if (sd_done) begin
          ui_nxt = dv_res; cr_nxt = FX_ONE; ci_nxt = '0;
          st_nxt = S_RUN; pc_nxt = 6'd3; k_nxt = '0;
        end
      end
      S_PIXA: begin
        // scale by inv_extent, floor
        px_nxt = (64'(im_r) * 64'($signed({1'b0, inv_r}))) >>> 28;
        py_nxt = (-64'(re_r) * 64'($signed({1'b0, inv_r}))) >>> 28;
        st_nxt = S_PIXB;
      end
      S_PIXB: begin
        sx = (px_r + 64'sd134217728) * 64'(CANVAS_WIDTH);
        sy = (py_r + 64'sd134217728) * 64'(CANVAS_HEIGHT);
        cx = (sx < 0) ? -((-sx) >>> 28) : (sx >>> 28);
        cy = (sy < 0) ? -((-sy) >>> 28) : (sy >>> 28);
        px_nxt = cx; py_nxt = cy;
        if (cx >= 0 && cx < CANVAS_WIDTH && cy >= 0 && cy < CANVAS_HEIGHT) begin
          ridx_nxt = AW'(cy) * AW'(CANVAS_WIDTH) + AW'(cx);
          st_nxt = S_PIXC;
        end else st_nxt = S_DONE;
      end
      S_PIXC: begin
        // first phase waits for the registered read, second updates the bin
        if (ph_r) begin
          cnt_nxt = (rdata == 16'hffff) ? rdata : rdata + 16'd1;
          we = 1'b1; wdata = cnt_nxt;
          view_nxt = 1'b1;
          col_nxt = px_r[9:0]; row_nxt = py_r[9:0];
          st_nxt = S_DONE; ph_nxt = 1'b0;
        end else ph_nxt = 1'b1;
      end
      S_RDA: begin
        if (32'(col_r) < CANVAS_WIDTH && 32'(row_r) < CANVAS_HEIGHT) begin
          ridx_nxt = AW'(row_r) * AW'(CANVAS_WIDTH) + AW'(col_r);
          st_nxt = S_RDB; ph_nxt = 1'b0;
        end else st_nxt = S_DONE;
      end
      S_RDB: begin
        if (ph_r) begin
          cnt_nxt = rdata;
          if (op_r == OP_RDCLR) begin
            we = 1'b1; wdata = '0;
          end
          st_nxt = S_DONE; ph_nxt = 1'b0;
        end else ph_nxt = 1'b1;
      end
      S_DONE: begin
        done_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLEAR; clr_r <= '0; done_r <= 1'b0;
      re_r <= RESET_RE; im_r <= RESET_IM; ph_r <= 1'b0; pc_r <= '0; k_r <= '0;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; done_r <= done_nxt;
      re_r <= re_nxt; im_r <= im_nxt; ph_r <= ph_nxt; pc_r <= pc_nxt; k_r <= k_nxt;
    end
    op_r <= op_nxt; col_r <= col_nxt; row_r <= row_nxt;
    nrm_r <= nrm_nxt; pr_r <= pr_nxt; pi_r <= pi_nxt; ur_r <= ur_nxt; ui_r <= ui_nxt;
    cr_r <= cr_nxt; ci_r <= ci_nxt; t0_r <= t0_nxt; t1_r <= t1_nxt; ext_r <= ext_nxt;
    g_r <= g_nxt; mag_r <= mag_nxt; nre_r <= nre_nxt; px_r <= px_nxt; py_r <= py_nxt;
    view_r <= view_nxt; cnt_r <= cnt_nxt; ridx_r <= ridx_nxt;
  end

  // result fields registered for the done cycle
  always_ff @(posedge clk) begin
    if (st_r == S_DONE) begin
      o_re_r <= re_r; o_im_r <= im_r; o_v_r <= view_r; o_n_r <= cnt_r;
      o_c_r <= (op_r == OP_PLOT || op_r == OP_READ || op_r == OP_RDCLR) &&
               (view_r || op_r != OP_PLOT) ? col_r : '0;
      o_rw_r <= (op_r == OP_PLOT || op_r == OP_READ || op_r == OP_RDCLR) &&
                (view_r || op_r != OP_PLOT) ? row_r : '0;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign done = done_r;
  assign out_point_real = o_re_r;
  assign out_point_imag = o_im_r;
  assign out_in_view = o_v_r;
  assign out_hit_col = o_c_r;
  assign out_hit_row = o_rw_r;
  assign out_bin_count = o_n_r;
endmodule
`default_nettype wire

// ===== hdl/siah_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module siah_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        start,
  input wire        busy,
  input wire        done,
  input wire        out_in_view,
  input wire [15:0] out_bin_count
);
  // an accepted item makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after accept");
  // a result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done longer than one cycle");
  // a plotted hit has a nonzero count
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    done && out_in_view |-> out_bin_count != 16'd0) else $error("empty hit");
endmodule
bind symmetric_icon_attractor_histogram siah_checker u_chk (.clk(clk), .rst_n(rst_n),
  .start(start), .busy(busy), .done(done), .out_in_view(out_in_view),
  .out_bin_count(out_bin_count));
`default_nettype wire

// ===== dv/tb_symmetric_icon_attractor_histogram.sv =====
`timescale 1ns / 1ps
module tb_symmetric_icon_attractor_histogram;
  import siah_pkg::*;

  localparam int  CANVAS_W  = 1024;
  localparam int  CANVAS_H  = 1024;
  localparam int  PMULT     = 1;
  localparam longint ONE    = 64'sd268435456;
  localparam longint HALF   = 64'sd134217728;
  // several times the reset clearing pass, far above the slowest step
  localparam int  IDLE_LIMIT = 4200000;

  // expected result of one item
  typedef struct {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               view;
    logic [9:0]         col;
    logic [9:0]         row;
    logic [15:0]        cnt;
  } icon_res_t;

  // directed stimulus row
  typedef struct {
    logic [2:0] op;
    logic [9:0] col;
    logic [9:0] row;
    bit         typed;
    icon_res_t  res;
  } icon_row_t;

  logic clk, rst_n, start, cfg_we;
  logic [2:0]  in_opcode, cfg_index;
  logic [9:0]  in_bin_col, in_bin_row;
  logic [31:0] cfg_data;
  wire         busy, done, out_in_view;
  wire signed [31:0] out_point_real, out_point_imag;
  wire [9:0]   out_hit_col, out_hit_row;
  wire [15:0]  out_bin_count;

  symmetric_icon_attractor_histogram dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_bin_col(in_bin_col), .in_bin_row(in_bin_row),
    .done(done), .out_point_real(out_point_real), .out_point_imag(out_point_imag),
    .out_in_view(out_in_view), .out_hit_col(out_hit_col), .out_hit_row(out_hit_row),
    .out_bin_count(out_bin_count), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic signed [31:0] g_lambda, g_alpha, g_beta, g_gamma, g_delta, g_omega;
  logic [4:0]  sym_n;
  logic [30:0] view_scale;
  logic signed [31:0] cur_re, cur_im;
  bit [15:0]   density [int];

  icon_res_t pending_res[$];
  int  errors;
  int  items_sent;
  int  idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic signed [31:0] sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // rounded q4.28 product, floor via arithmetic shift
  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b) + HALF;
    return sat(p >>> 28);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return sat(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return sat(longint'(a) - longint'(b));
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // one iteration of the icon map
  task automatic icon_advance();
    logic signed [31:0] re, im, norm, extra, pr, pi, tr, ti, ur, ui, cr, ci;
    logic signed [31:0] zn_re, gain;
    longint mag;
    int n;
    re = cur_re;
    im = cur_im;
    n = (sym_n < 2) ? 2 : sym_n;
    norm = qadd(qmul(re, re), qmul(im, im));
    extra = 0;
    pr = re;
    pi = im;
    if (g_delta != 0) begin
      mag = longint'(root_floor(longint'(norm < 0 ? 0 : norm) * ONE));
      // zero magnitude leaves the delta term at zero
      if (mag != 0) begin
        ur = sat((longint'(re) * ONE) / mag);
        ui = sat((longint'(im) * ONE) / mag);
        cr = ONE[31:0];
        ci = 0;
        for (int k = 0; k < n * PMULT; k++) begin
          tr = qsub(qmul(ur, cr), qmul(ui, ci));
          ti = qadd(qmul(ur, ci), qmul(ui, cr));
          cr = tr;
          ci = ti;
        end
        extra = qmul(cr, sat(mag));
      end
    end
    for (int k = 0; k + 2 < n; k++) begin
      tr = qsub(qmul(pr, re), qmul(pi, im));
      ti = qadd(qmul(pi, re), qmul(pr, im));
      pr = tr;
      pi = ti;
    end
    zn_re = qsub(qmul(re, pr), qmul(im, pi));
    gain = qadd(g_lambda, qmul(g_alpha, norm));
    gain = qadd(gain, qmul(g_beta, zn_re));
    gain = qadd(gain, qmul(g_delta, extra));
    cur_re = qsub(qadd(qmul(gain, re), qmul(g_gamma, pr)), qmul(g_omega, im));
    cur_im = qadd(qsub(qmul(gain, im), qmul(g_gamma, pi)), qmul(g_omega, re));
  endtask

  function automatic longint pixel_of(input longint coord, input longint size);
    longint s;
    s = (coord * longint'({1'b0, view_scale})) >>> 28;
    return ((s + HALF) * size) / ONE;
  endfunction

  // expected result of one accepted item, updating predictor state
  task automatic predict_item(input logic [2:0] op, input logic [9:0] col,
                              input logic [9:0] row, output icon_res_t r);
    longint px, py;
    int idx;
    r.view = 0;
    r.col = 0;
    r.row = 0;
    r.cnt = 0;
    case (op)
      OP_RESTART: begin
        cur_re = RESET_RE;
        cur_im = RESET_IM;
      end
      OP_STEP, OP_PLOT: begin
        icon_advance();
        if (op == OP_PLOT) begin
          px = pixel_of(longint'(cur_im), CANVAS_W);
          py = pixel_of(-longint'(cur_re), CANVAS_H);
          if (px >= 0 && px < CANVAS_W && py >= 0 && py < CANVAS_H) begin
            idx = int'(py) * CANVAS_W + int'(px);
            if (density[idx] != 16'hffff) density[idx] = density[idx] + 1;
            r.view = 1;
            r.col = px[9:0];
            r.row = py[9:0];
            r.cnt = density[idx];
          end
        end
      end
      OP_READ, OP_RDCLR: begin
        r.col = col;
        r.row = row;
        idx = int'(row) * CANVAS_W + int'(col);
        r.cnt = density[idx];
        if (op == OP_RDCLR) density[idx] = 0;
      end
      default: ;
    endcase
    r.re = cur_re;
    r.im = cur_im;
  endtask

  // register write, predictor mirrors it
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LAMBDA: g_lambda = val;
      CFG_ALPHA:  g_alpha = val;
      CFG_BETA:   g_beta = val;
      CFG_GAMMA:  g_gamma = val;
      CFG_DELTA:  g_delta = val;
      CFG_OMEGA:  g_omega = val;
      CFG_DEGREE: sym_n = val[4:0];
      CFG_INVEXT: view_scale = val[30:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] la, input logic [31:0] al,
                           input logic [31:0] be, input logic [31:0] ga,
                           input logic [31:0] de, input logic [31:0] om,
                           input logic [31:0] dg, input logic [31:0] ie);
    write_reg(CFG_LAMBDA, la);
    write_reg(CFG_ALPHA, al);
    write_reg(CFG_BETA, be);
    write_reg(CFG_GAMMA, ga);
    write_reg(CFG_DELTA, de);
    write_reg(CFG_OMEGA, om);
    write_reg(CFG_DEGREE, dg);
    write_reg(CFG_INVEXT, ie);
  endtask

  // offer one item and hold it until taken
  task automatic send_item(input logic [2:0] op, input logic [9:0] col,
                           input logic [9:0] row, input bit typed,
                           input icon_res_t typed_res);
    icon_res_t r;
    int gap;
    // random idling, none in the middle stretch
    if (!(items_sent >= 300 && items_sent < 450) && $urandom_range(99) < 32) begin
      gap = $urandom_range(6, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_bin_col <= col;
    in_bin_row <= row;
    do @(posedge clk); while (busy);
    predict_item(op, col, row, r);
    pending_res.push_back(typed ? typed_res : r);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_item(input bit shaped);
    icon_res_t none;
    logic [2:0] op;
    int pick;
    pick = $urandom_range(99);
    if (!shaped) op = $urandom_range(7);
    else if (pick < 50) op = OP_PLOT;
    else if (pick < 68) op = OP_STEP;
    else if (pick < 82) op = OP_READ;
    else if (pick < 92) op = OP_RDCLR;
    else if (pick < 95) op = OP_RESTART;
    else op = $urandom_range(7, 5);
    none = '{default: 0};
    send_item(op, $urandom_range(1023), $urandom_range(1023), 1'b0, none);
  endtask

  // result checker
  always @(posedge clk) begin
    icon_res_t e;
    if (rst_n && done) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected item re=%h im=%h", $time, out_point_real,
                 out_point_imag);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_point_real !== e.re) begin
          $display("%0t: point_real exp %h got %h", $time, e.re, out_point_real);
          errors++;
        end
        if (out_point_imag !== e.im) begin
          $display("%0t: point_imag exp %h got %h", $time, e.im, out_point_imag);
          errors++;
        end
        if (out_in_view !== e.view) begin
          $display("%0t: in_view exp %h got %h", $time, e.view, out_in_view);
          errors++;
        end
        if (out_hit_col !== e.col) begin
          $display("%0t: hit_col exp %h got %h", $time, e.col, out_hit_col);
          errors++;
        end
        if (out_hit_row !== e.row) begin
          $display("%0t: hit_row exp %h got %h", $time, e.row, out_hit_row);
          errors++;
        end
        if (out_bin_count !== e.cnt) begin
          $display("%0t: bin_count exp %h got %h", $time, e.cnt, out_bin_count);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted and no result
  always @(posedge clk) begin
    if ((start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  icon_row_t dir_rows[$];

  initial begin
    icon_res_t rst_pt, none;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_opcode = OP_STEP;
    in_bin_col = '0;
    in_bin_row = '0;
    g_lambda = 0; g_alpha = 0; g_beta = 0; g_gamma = 0; g_delta = 0; g_omega = 0;
    sym_n = 5'd3;
    view_scale = 31'h1000_0000;
    cur_re = RESET_RE;
    cur_im = RESET_IM;
    none = '{default: 0};
    rst_pt = '{re: RESET_RE, im: RESET_IM, view: 0, col: 0, row: 0, cnt: 0};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset values, reads at corners, every opcode
    dir_rows.push_back('{OP_READ, 10'd0, 10'd0, 1, rst_pt});
    dir_rows.push_back('{OP_RDCLR, 10'd1023, 10'd1023, 1,
      '{RESET_RE, RESET_IM, 1'b0, 10'd1023, 10'd1023, 16'd0}});
    dir_rows.push_back('{3'd5, 10'd1023, 10'd0, 1, rst_pt});
    dir_rows.push_back('{3'd6, 10'd0, 10'd1023, 1, rst_pt});
    dir_rows.push_back('{3'd7, 10'd512, 10'd512, 1, rst_pt});
    dir_rows.push_back('{OP_STEP, 10'd0, 10'd0, 0, none});
    dir_rows.push_back('{OP_PLOT, 10'd0, 10'd0, 0, none});
    dir_rows.push_back('{OP_PLOT, 10'd0, 10'd0, 0, none});
    dir_rows.push_back('{OP_RESTART, 10'd0, 10'd0, 1, rst_pt});
    dir_rows.push_back('{OP_PLOT, 10'd0, 10'd0, 0, none});
    dir_rows.push_back('{OP_READ, 10'd512, 10'd512, 0, none});
    dir_rows.push_back('{OP_RDCLR, 10'd512, 10'd512, 0, none});
    dir_rows.push_back('{OP_READ, 10'd512, 10'd512, 0, none});
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].col, dir_rows[i].row,
                dir_rows[i].typed, dir_rows[i].res);
    drain();

    // zero magnitude: collapse to the origin, then step with delta on
    write_all(0, 0, 0, 0, 0, 0, 1, 32'h0800_0000);
    send_item(OP_PLOT, 0, 0, 0, none);
    drain();
    write_reg(CFG_DELTA, 32'h0400_0000);
    send_item(OP_PLOT, 0, 0, 0, none);
    send_item(OP_PLOT, 0, 0, 0, none);
    send_item(OP_READ, 10'd512, 10'd512, 0, none);
    drain();

    // extremes of every register, degree zero and largest window scale
    write_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
              32'h7fff_ffff, 32'h8000_0000, 0, 32'h7fff_ffff);
    send_item(OP_RESTART, 0, 0, 0, none);
    repeat (4) send_item(OP_PLOT, 0, 0, 0, none);
    drain();
    write_all(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h7fff_ffff, 16, 1);
    send_item(OP_RESTART, 0, 0, 0, none);
    repeat (3) send_item(OP_PLOT, 0, 0, 0, none);
    drain();

    // random phases: known icon settings, then random small gains
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_all(-32'sd558345748, 32'sd268435456, -32'sd26843546, 32'sd44828721,
                     0, 0, 7, 32'sd134217728);
        1: write_all(32'sd418759311, -32'sd268435456, 32'sd26843546,
                     -32'sd220117074, 0, 0, 3, 32'sd134217728);
        2: write_all(-32'sd558345748, 32'sd268435456, -32'sd26843546, 32'sd44828721,
                     32'sd26843546, 32'sd2684354, 5, 32'sd134217728);
        3: write_all(-32'sd322122547, 32'sd268435456, 0, 32'sd53687091,
                     0, 32'sd26843546, 2, 32'sd67108864);
        default: write_all($urandom_range(32'h1000_0000) - 32'h0800_0000,
                           $urandom_range(32'h1000_0000) - 32'h0800_0000,
                           $urandom_range(32'h1000_0000) - 32'h0800_0000,
                           $urandom_range(32'h1000_0000) - 32'h0800_0000,
                           (ph == 5) ? $urandom() : 0,
                           $urandom_range(32'h1000_0000) - 32'h0800_0000,
                           $urandom_range(16), $urandom());
      endcase
      send_item(OP_RESTART, 0, 0, 0, none);
      for (int k = 0; k < 155; k++) random_item(k % 10 != 9);
      drain();
    end

    repeat (40) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
